/* rtl/assert_macros.svh */
// Assertion helpers for the block checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled during reset.
`define SCWE_CHECK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scwe check failed");

// Same with a caller supplied message.
`define SCWE_CHECK_MSG(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

/* rtl/scwe_pkg.sv */
package scwe_pkg;

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_AT    = 8'h40;
    localparam logic [7:0] CHAR_M     = 8'h4D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [3:0] NO_FIELD    = 4'd15;
    localparam logic [3:0] FIELD_SAT   = 4'd14;
    localparam logic [3:0] CIGAR_FIELD = 4'd5;
    localparam logic [3:0] SEQ_FIELD   = 4'd9;
    localparam logic [3:0] QUAL_FIELD  = 4'd10;

    localparam logic [1:0] KIND_SEQ  = 2'd0;
    localparam logic [1:0] KIND_QUAL = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic [1:0] kind;
    } scwe_result_t;

endpackage

/* rtl/sam_cigar_window_extractor_top.sv */
// Takes alignment text one byte per transfer, skips leading '@' header lines,
// parses the CIGAR field of each data line and returns the sequence and
// quality bytes inside the first M window with a nonzero offset before it, then
// an end marker (kind 2, byte 0) at the newline. For each byte, the parse state
// updates on the input transfer and any result lands in a single output
// register, so a byte can be taken every cycle while the output drains.
// text_stall is high only while that register holds a result that the
// consumer is stalling. Lengths and positions are LENGTH_BITS wide and saturate.
module sam_cigar_window_extractor_top #(
    parameter int LENGTH_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_stall,
    input  logic [7:0] text_byte,
    output logic       item_valid,
    input  logic       item_stall,
    output logic [7:0] out_byte,
    output logic [1:0] item_kind
);

    scwe_pkg::scwe_result_t result;
    logic       accept;
    logic       item_valid_reg, item_valid_next;
    logic [7:0] out_byte_reg;
    logic [1:0] item_kind_reg;

    assign text_stall = item_valid_reg && item_stall;
    assign accept     = text_valid && !text_stall;

    scwe_parser #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .text_byte(text_byte),
        .result   (result)
    );

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
            item_valid_next = result.valid;
        else if (!item_stall)
            item_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && result.valid)
        begin
            out_byte_reg  <= result.data;
            item_kind_reg <= result.kind;
        end
    end

    assign item_valid = item_valid_reg;
    assign out_byte   = out_byte_reg;
    assign item_kind  = item_kind_reg;

endmodule

/* rtl/scwe_parser.sv */
module scwe_parser #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           text_byte,
    output scwe_pkg::scwe_result_t result
);

    localparam int L = LENGTH_BITS;
    localparam logic [L-1:0] LEN_MAX = {L{1'b1}};

    logic         in_header_reg,     in_header_next;
    logic         at_line_start_reg, at_line_start_next;
    logic         line_is_data_reg,  line_is_data_next;
    logic         in_token_reg,      in_token_next;
    logic [3:0]   field_number_reg,  field_number_next;
    logic [L-1:0] number_accum_reg,  number_accum_next;
    logic [L-1:0] skip_offset_reg,   skip_offset_next;
    logic [L-1:0] window_length_reg, window_length_next;
    logic         window_found_reg,  window_found_next;
    logic [L-1:0] field_position_reg, field_position_next;

    logic         hdr_eff;
    logic         data_eff;
    logic [3:0]   fn_eff;
    logic [L-1:0] pos_eff;
    logic [L-1:0] acc_eff;
    logic [L+4:0] acc_x10;
    logic [L:0]   skip_sum;
    logic [L:0]   pos_sum;
    logic [L:0]   win_end;
    logic         is_digit;
    logic         in_window;

    always_comb
    begin
        hdr_eff  = in_header_reg;
        data_eff = line_is_data_reg;
        if (at_line_start_reg)
        begin
            hdr_eff  = in_header_reg && (text_byte == scwe_pkg::CHAR_AT);
            data_eff = !hdr_eff;
        end

        fn_eff  = field_number_reg;
        pos_eff = field_position_reg;
        acc_eff = number_accum_reg;
        if (!in_token_reg)
        begin
            if (field_number_reg == scwe_pkg::NO_FIELD)
                fn_eff = 4'd0;
            else if (field_number_reg < scwe_pkg::FIELD_SAT)
                fn_eff = field_number_reg + 4'd1;
            pos_eff = '0;
            acc_eff = '0;
        end

        is_digit = (text_byte >= scwe_pkg::CHAR_ZERO) && (text_byte <= scwe_pkg::CHAR_NINE);
        acc_x10  = ({5'b0, acc_eff} << 3) + ({5'b0, acc_eff} << 1)
                 + {{(L+1){1'b0}}, text_byte[3:0]};
        skip_sum = {1'b0, skip_offset_reg} + {1'b0, acc_eff};
        pos_sum  = {1'b0, pos_eff} + {{L{1'b0}}, 1'b1};
        win_end  = {1'b0, skip_offset_reg} + {1'b0, window_length_reg};
        in_window = (pos_eff != LEN_MAX) && (pos_eff >= skip_offset_reg)
                 && ({1'b0, pos_eff} < win_end);

        in_header_next      = hdr_eff;
        at_line_start_next  = 1'b0;
        line_is_data_next   = data_eff;
        in_token_next       = in_token_reg;
        field_number_next   = field_number_reg;
        number_accum_next   = number_accum_reg;
        skip_offset_next    = skip_offset_reg;
        window_length_next  = window_length_reg;
        window_found_next   = window_found_reg;
        field_position_next = field_position_reg;

        result.valid = 1'b0;
        result.data  = text_byte;
        result.kind  = scwe_pkg::KIND_SEQ;

        if (text_byte == scwe_pkg::CHAR_NL)
        begin
            if (data_eff && window_found_reg)
            begin
                result.valid = 1'b1;
                result.data  = 8'd0;
                result.kind  = scwe_pkg::KIND_END;
            end
            at_line_start_next  = 1'b1;
            line_is_data_next   = 1'b0;
            in_token_next       = 1'b0;
            field_number_next   = scwe_pkg::NO_FIELD;
            number_accum_next   = '0;
            skip_offset_next    = '0;
            window_length_next  = '0;
            window_found_next   = 1'b0;
            field_position_next = '0;
        end
        else if (data_eff)
        begin
            if (text_byte == scwe_pkg::CHAR_TAB)
            begin
                in_token_next = 1'b0;
            end
            else
            begin
                in_token_next       = 1'b1;
                field_number_next   = fn_eff;
                number_accum_next   = acc_eff;
                field_position_next = pos_sum[L] ? LEN_MAX : pos_sum[L-1:0];
                if (fn_eff == scwe_pkg::CIGAR_FIELD)
                begin
                    if (!window_found_reg)
                    begin
                        if (is_digit)
                        begin
                            number_accum_next = (|acc_x10[L+4:L]) ? LEN_MAX : acc_x10[L-1:0];
                        end
                        else
                        begin
                            number_accum_next = '0;
                            if (text_byte == scwe_pkg::CHAR_M && skip_offset_reg != '0)
                            begin
                                window_length_next = acc_eff;
                                window_found_next  = 1'b1;
                            end
                            else
                            begin
                                skip_offset_next = skip_sum[L] ? LEN_MAX : skip_sum[L-1:0];
                            end
                        end
                    end
                end
                else if ((fn_eff == scwe_pkg::SEQ_FIELD || fn_eff == scwe_pkg::QUAL_FIELD)
                         && window_found_reg && in_window)
                begin
                    result.valid = 1'b1;
                    result.kind  = (fn_eff == scwe_pkg::SEQ_FIELD) ? scwe_pkg::KIND_SEQ
                                                                   : scwe_pkg::KIND_QUAL;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_header_reg      <= 1'b1;
            at_line_start_reg  <= 1'b1;
            line_is_data_reg   <= 1'b0;
            in_token_reg       <= 1'b0;
            field_number_reg   <= scwe_pkg::NO_FIELD;
            number_accum_reg   <= '0;
            skip_offset_reg    <= '0;
            window_length_reg  <= '0;
            window_found_reg   <= 1'b0;
            field_position_reg <= '0;
        end
        else if (accept)
        begin
            in_header_reg      <= in_header_next;
            at_line_start_reg  <= at_line_start_next;
            line_is_data_reg   <= line_is_data_next;
            in_token_reg       <= in_token_next;
            field_number_reg   <= field_number_next;
            number_accum_reg   <= number_accum_next;
            skip_offset_reg    <= skip_offset_next;
            window_length_reg  <= window_length_next;
            window_found_reg   <= window_found_next;
            field_position_reg <= field_position_next;
        end
    end

endmodule

/* rtl/scwe_checker.sv */
`include "assert_macros.svh"

module scwe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       text_valid,
    input logic       text_stall,
    input logic       item_valid,
    input logic       item_stall,
    input logic [7:0] out_byte,
    input logic [1:0] item_kind
);

    `SCWE_CHECK(a_kind_range, item_valid |-> (item_kind != 2'd3))
    `SCWE_CHECK_MSG(a_end_zero,
        (item_valid && item_kind == scwe_pkg::KIND_END) |-> (out_byte == 8'd0),
        "end marker carries nonzero byte")
    `SCWE_CHECK(a_stall_only_full, text_stall |-> (item_valid && item_stall))
    `SCWE_CHECK_MSG(a_result_from_input,
        $rose(item_valid) |-> $past(text_valid && !text_stall),
        "result without input transfer")
    `SCWE_CHECK(a_out_hold,
        (item_valid && item_stall) |=> (item_valid && $stable(out_byte) && $stable(item_kind)))

endmodule

bind sam_cigar_window_extractor_top scwe_checker u_scwe_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int LEN_BITS = 16;
    localparam int unsigned LEN_MAX = (1 << LEN_BITS) - 1;
    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD = 150;

    typedef struct {
        logic [7:0] data;
        logic [1:0] kind;
    } extract_item_t;

    logic       clk;
    logic       rst_n;
    logic       text_valid;
    logic       text_stall;
    logic [7:0] text_byte;
    logic       item_valid;
    logic       item_stall;
    logic [7:0] out_byte;
    logic [1:0] item_kind;

    extract_item_t pending_items[$];
    logic [7:0]    line_buf[$];

    // predicted parse state
    logic        hdr_mode;
    logic        line_start;
    logic        data_line;
    logic        in_tok;
    logic [3:0]  fld;
    int unsigned num_acc;
    int unsigned skip_off;
    int unsigned win_len;
    logic        win_found;
    int unsigned fpos;

    int  errors;
    int  bytes_sent;
    int  results_checked;
    int  end_markers;
    int  idle_cycles;
    int  hold_cnt;
    int  stall_cycles;
    bit  no_idle;
    bit  long_hold_req;

    sam_cigar_window_extractor_top #(
        .LENGTH_BITS(LEN_BITS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_byte  (text_byte),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .out_byte   (out_byte),
        .item_kind  (item_kind)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string msg);
        errors++;
        $display("tb: mismatch at %0t: %s", $realtime, msg);
    endtask

    function automatic int unsigned sat_len(input int unsigned v);
        return (v > LEN_MAX) ? LEN_MAX : v;
    endfunction

    function automatic void clear_line_state();
        in_tok    = 1'b0;
        fld       = scwe_pkg::NO_FIELD;
        num_acc   = 0;
        skip_off  = 0;
        win_len   = 0;
        win_found = 1'b0;
        fpos      = 0;
    endfunction

    function automatic void push_item(input logic [7:0] d, input logic [1:0] k);
        extract_item_t it;
        it.data = d;
        it.kind = k;
        pending_items.push_back(it);
    endfunction

    function automatic void track_text(input logic [7:0] c);
        if (line_start)
        begin
            line_start = 1'b0;
            if (hdr_mode && c != scwe_pkg::CHAR_AT)
                hdr_mode = 1'b0;
            data_line = !hdr_mode;
        end
        if (c == scwe_pkg::CHAR_NL)
        begin
            if (data_line && win_found)
                push_item(8'd0, scwe_pkg::KIND_END);
            clear_line_state();
            line_start = 1'b1;
            data_line  = 1'b0;
            return;
        end
        if (!data_line)
            return;
        if (c == scwe_pkg::CHAR_TAB)
        begin
            in_tok = 1'b0;
            return;
        end
        if (!in_tok)
        begin
            in_tok = 1'b1;
            if (fld == scwe_pkg::NO_FIELD)
                fld = 4'd0;
            else if (fld < scwe_pkg::FIELD_SAT)
                fld = fld + 4'd1;
            fpos    = 0;
            num_acc = 0;
        end
        if (fld == scwe_pkg::CIGAR_FIELD)
        begin
            if (!win_found)
            begin
                if (c >= scwe_pkg::CHAR_ZERO && c <= scwe_pkg::CHAR_NINE)
                begin
                    num_acc = sat_len(num_acc * 10 + (32'(c) - 32'(scwe_pkg::CHAR_ZERO)));
                end
                else
                begin
                    if (c == scwe_pkg::CHAR_M && skip_off > 0)
                    begin
                        win_len   = num_acc;
                        win_found = 1'b1;
                    end
                    else
                    begin
                        skip_off = sat_len(skip_off + num_acc);
                    end
                    num_acc = 0;
                end
            end
        end
        else if ((fld == scwe_pkg::SEQ_FIELD || fld == scwe_pkg::QUAL_FIELD) && win_found)
        begin
            if (fpos != LEN_MAX && fpos >= skip_off && fpos < skip_off + win_len)
                push_item(c, (fld == scwe_pkg::SEQ_FIELD) ? scwe_pkg::KIND_SEQ
                                                          : scwe_pkg::KIND_QUAL);
        end
        fpos = sat_len(fpos + 1);
    endfunction

    task automatic send_text(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_byte  <= b;
        @(posedge clk);
        while (text_stall) @(posedge clk);
        track_text(b);
        bytes_sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_text(s[i]);
    endtask

    task automatic send_buf();
        foreach (line_buf[i])
            send_text(line_buf[i]);
    endtask

    task automatic drain_results();
        text_valid <= 1'b0;
        @(posedge clk);
        while (pending_items.size() > 0) @(posedge clk);
    endtask

    task automatic add_random(input int lo, input int hi, input int n);
        repeat (n) line_buf.push_back(8'($urandom_range(lo, hi)));
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic add_cigar();
        string ops;
        string lead;
        int    nops;
        int    len;
        ops  = "MIDNSHP=X";
        lead = "SHI";
        if ($urandom_range(0, 99) < 6)
        begin
            add_str("*");
            return;
        end
        nops = $urandom_range(1, 4);
        for (int i = 0; i < nops; i++)
        begin
            if ($urandom_range(0, 9) != 0)
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 99999)
                                                   : $urandom_range(0, 12);
                add_str($sformatf("%0d", len));
            end
            if (i == 0 && $urandom_range(0, 3) != 0)
                line_buf.push_back(lead[$urandom_range(0, 2)]);
            else if (i == 1 && $urandom_range(0, 1) == 0)
                line_buf.push_back(scwe_pkg::CHAR_M);
            else
                line_buf.push_back(ops[$urandom_range(0, 8)]);
            if ($urandom_range(0, 29) == 0)
                add_random(33, 126, 1);
        end
        if ($urandom_range(0, 9) == 0)
            add_random(48, 57, $urandom_range(1, 2));
    endtask

    task automatic build_record();
        string bases;
        int    shape;
        int    last_fld;
        bases = "ACGTN";
        line_buf.delete();
        shape = $urandom_range(0, 99);
        if (shape < 8)
        begin
            add_random(0, 255, $urandom_range(1, 24));
            line_buf.push_back(scwe_pkg::CHAR_NL);
            return;
        end
        last_fld = (shape < 20) ? $urandom_range(0, 16) : 10;
        if (shape < 23)
            line_buf.push_back(scwe_pkg::CHAR_TAB);
        for (int f = 0; f <= last_fld; f++)
        begin
            if (f > 0)
            begin
                line_buf.push_back(scwe_pkg::CHAR_TAB);
                if ($urandom_range(0, 19) == 0)
                    line_buf.push_back(scwe_pkg::CHAR_TAB);
            end
            if (f == 5)
            begin
                add_cigar();
            end
            else if (f == 9)
            begin
                repeat ($urandom_range(0, 16))
                    line_buf.push_back(bases[$urandom_range(0, 4)]);
            end
            else if (f == 10)
            begin
                add_random(33, 126, $urandom_range(0, 16));
            end
            else
            begin
                add_random(33, 255, $urandom_range(1, 3));
            end
        end
        if ($urandom_range(0, 29) != 0)
            line_buf.push_back(scwe_pkg::CHAR_NL);
    endtask

    task automatic test_header_skip();
        send_str("@HD\tVN:1.6\n@SQ\tSN:c1\tLN:9\n");
        send_str("r1\t0\tc1\t1\t9\t1S2M\t*\t0\t0\tACGT\tABCD\n");
        send_str("@late\t0\tc1\t1\t9\t1H1M\t*\t0\t0\tGT\tXY\n");
    endtask

    task automatic test_cigar_forms();
        send_str("q1\t0\tc\t1\t9\t*\t*\t0\t0\tACGT\tIIII\n");
        send_str("q2\t0\tc\t1\t9\t3S0M\t*\t0\t0\tACGTAC\tIIIIII\n");
        send_str("q3\t0\tc\t1\t9\t2SH3M\t*\t0\t0\tACGTACG\tABCDEFG\n");
        send_str("q4\t0\tc\t1\t9\t4M2M\t*\t0\t0\tACGTACGT\tABCDEFGH\n");
        send_str("q5\t0\tc\t1\t9\t2S7\t*\t0\t0\tACGTACGT\tABCDEFGH\n");
        send_str("q6\t0\tc\t1\t9\t5S3I\t*\t0\t0\tACGTACGT\tABCDEFGH\n");
        send_str("q7\t0\tc\t1\t9\t1S2M3S4M\t*\t0\t0\tACGTACGT\tABCDEFGH\n");
    endtask

    task automatic test_field_shapes();
        send_str("s1\t0\tc\t1\t9\t1S10M\t*\t0\t0\tACG\tII\n");
        send_str("s2\t0\tc\t1\t9\t1S2M\t*\t0\t0\tACGTA\n");
        send_str("s3\t0\tc\t1\t9\t1S2M\t*\t0\n");
        send_str("\ts4\t\t0\tc\t\t1\t9\t1S2M\t*\t0\t0\tACGT\tIJKL");
        send_str("\tX1\tX2\tX3\tX4\tACGT\tX6\n\n\n");
    endtask

    task automatic test_saturation();
        send_str("z1\t0\tc\t1\t9\t65530S10M\t*\t0\t0\tACGT\tIIIII\n");
        send_str("z2\t0\tc\t1\t9\t1S99999M\t*\t0\t0\tACGTACGT\tIIII\n");
        send_str("z3\t0\tc\t1\t9\t99999S0M\t*\t0\t0\tACGT\tIIII\n");
        send_str("z4\t0\tc\t1\t9\t4294967299S1M\t*\t0\t0\tACGT\tIIII\n");
        drain_results();
    endtask

    task automatic test_output_backpressure();
        long_hold_req = 1'b1;
        no_idle       = 1'b1;
        send_str("b1\t0\tc\t1\t9\t1S60M\t*\t0\t0\t");
        repeat (61) send_text("G");
        send_str("\tJJJJJJJJJJJJJJJJJJJJ\n");
        no_idle = 1'b0;
        drain_results();
    endtask

    task automatic test_random_records();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < 1000)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            build_record();
            send_buf();
            if ($urandom_range(0, 9) == 0)
                drain_results();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_unterminated_tail();
        send_str("t1\t0\tc\t1\t9\t2S3M\t*\t0\t0\tACGTAC\tABCDEF");
    endtask

    // result side: random stall per transfer, long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && item_valid && !item_stall)
            begin
                extract_item_t want;
                results_checked++;
                if (pending_items.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result byte %02h kind %0d",
                                              out_byte, item_kind));
                end
                else
                begin
                    want = pending_items.pop_front();
                    if (item_kind !== want.kind)
                        report_mismatch($sformatf("item_kind %0d, expected %0d",
                                                  item_kind, want.kind));
                    if (out_byte !== want.data)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  out_byte, want.data));
                    if (want.kind == scwe_pkg::KIND_END)
                        end_markers++;
                end
                hold_cnt = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (long_hold_req)
            begin
                hold_cnt      = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_cnt > 0)
            begin
                item_stall <= 1'b1;
                hold_cnt--;
            end
            else
            begin
                item_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text_valid && text_stall)
                stall_cycles++;
            if ((text_valid && !text_stall) || (item_valid && !item_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: no transfer for %0d cycles", IDLE_LIMIT);
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        text_valid    = 1'b0;
        text_byte     = 8'h00;
        item_stall    = 1'b0;
        errors        = 0;
        bytes_sent    = 0;
        results_checked = 0;
        end_markers   = 0;
        idle_cycles   = 0;
        hold_cnt      = 0;
        stall_cycles  = 0;
        no_idle       = 1'b0;
        long_hold_req = 1'b0;
        hdr_mode      = 1'b1;
        line_start    = 1'b1;
        data_line     = 1'b0;
        clear_line_state();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_skip();
        test_cigar_forms();
        test_field_shapes();
        drain_results();
        test_saturation();
        test_output_backpressure();
        test_random_records();
        test_unterminated_tail();

        drain_results();
        repeat (8) @(posedge clk);

        $display("tb: %0d text bytes sent, %0d results checked, %0d window records closed",
                 bytes_sent, results_checked, end_markers);
        $display("tb: input held off for %0d cycles by output back-pressure", stall_cycles);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
